### hw/rtl/fqa_pkg.sv
// Shared types, constants and arcsine table builder for the vector angle block.
package fqa_pkg;

  localparam int unsigned FracBitsDef  = 20;
  localparam int unsigned TableBitsDef = 10;
  localparam int unsigned VecWidth     = 32;
  localparam int unsigned AngleWidth   = 21;
  localparam int unsigned MagWidth     = 32;
  localparam int unsigned RootSteps    = 32;
  localparam int unsigned RomWidth     = 29;
  localparam int unsigned RomFrac      = 30;
  localparam int unsigned CordicSteps  = 30;

  // atan(2^-k) with 2^32 per turn
  localparam longint CordicAngle [CordicSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct packed {
    logic signed [VecWidth-1:0] vec_real;
    logic signed [VecWidth-1:0] vec_imag;
  } fqa_in_t;

  typedef struct packed {
    logic [AngleWidth-1:0] angle_turns;
    logic                  zero_vector;
  } fqa_out_t;

  typedef struct packed {
    logic zero;
    logic re_pos;
    logic im_neg;
  } fqa_side_t;

  typedef struct packed {
    logic                vld;
    fqa_side_t           side;
    logic [MagWidth-1:0] mag;
    logic [MagWidth-1:0] aim;
  } fqa_root_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = v;
    root = 0;
    bitv = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // asin(i / 2^tb) / (2*pi) in Q30 turns, rounded to nearest
  function automatic logic [RomWidth-1:0] arcsine_entry(input int unsigned i,
                                                        input int unsigned tb);
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint unsigned s;
    if (i == 0) return '0;
    if (i >= (32'd1 << tb)) return RomWidth'(64'd1 << 28);
    s = longint'(i) << (30 - tb);
    y = longint'(s);
    x = longint'(isqrt64((64'd1 << 60) - s * s));
    z = 0;
    for (int k = 0; k < CordicSteps; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + CordicAngle[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - CordicAngle[k];
      end
    end
    if (z < 0) z = 0;
    z = (z + 2) >>> 2;
    if (z > (64'sd1 <<< 28)) z = 64'sd1 <<< 28;
    return RomWidth'(z);
  endfunction

endpackage

### hw/rtl/four_quadrant_angle_from_vector_top.sv
// Top level of the four-quadrant vector angle pipeline.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_stall_o   fqa_in_t  (vec_real, vec_imag)
//   out      out  out_valid_o / out_stall_i fqa_out_t (angle_turns, zero_vector)
//
// One item enters per cycle while no stalled result waits at the output. The
// pipeline has stages for absolute values, squares and their sum, 32 square-root
// stages, FracBits + 1 divider stages and four lookup stages ending in the
// output register. The ROM is a constant table, so reset only clears valids.
// A stalled result freezes the whole pipeline, which holds every item in place.
module four_quadrant_angle_from_vector_top import fqa_pkg::*; #(
  parameter int unsigned FracBits  = FracBitsDef,
  parameter int unsigned TableBits = TableBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fqa_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fqa_out_t out_item_o
);

  logic              en;
  fqa_root_t         root;
  logic              div_vld;
  fqa_side_t         div_side;
  logic [FracBits:0] div_par;

  // advance every stage unless a finished item waits downstream
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  fqa_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .root_o     (root)
  );

  fqa_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .root_i (root),
    .vld_o  (div_vld),
    .side_o (div_side),
    .par_o  (div_par)
  );

  fqa_lookup #(
    .FracBits  (FracBits),
    .TableBits (TableBits)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (div_vld),
    .side_i      (div_side),
    .par_i       (div_par),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // zero vector always reports angle zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.zero_vector |-> out_item_o.angle_turns == '0)
    else $error("zero vector with nonzero angle");

  // angle never exceeds one full turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {11'b0, out_item_o.angle_turns} <= (32'd1 << FracBits))
    else $error("angle beyond one turn");

  // a stall on the output keeps the result in place and blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o ##1 out_valid_o)
    else $error("stalled result lost");

endmodule

### hw/rtl/fqa_sqrt.sv
// Magnitude pipeline: absolute values, squares, sum and a bit-per-stage square root.
module fqa_sqrt import fqa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  fqa_in_t   in_item_i,
  output fqa_root_t root_o
);

  localparam int unsigned SqWidth = 2 * MagWidth;

  logic                abs_vld_q;
  logic [MagWidth-1:0] are_q;
  logic [MagWidth-1:0] aim_a_q;
  fqa_side_t           side_a_q;

  logic                sq_vld_q;
  logic [SqWidth-1:0]  sq_re_q;
  logic [SqWidth-1:0]  sq_im_q;
  logic [MagWidth-1:0] aim_b_q;
  fqa_side_t           side_b_q;

  // index 0 holds the sum of squares, index k the state after root step k
  logic                vld_q  [RootSteps+1];
  logic [SqWidth-1:0]  rem_q  [RootSteps+1];
  logic [SqWidth-1:0]  root_q [RootSteps+1];
  logic [MagWidth-1:0] aim_q  [RootSteps+1];
  fqa_side_t           side_q [RootSteps+1];

  logic [SqWidth-1:0]  trial [1:RootSteps];
  logic                take  [1:RootSteps];

  logic [MagWidth-1:0] are_d;
  logic [MagWidth-1:0] aim_d;

  assign are_d = in_item_i.vec_real[VecWidth-1] ? (~in_item_i.vec_real + 32'd1)
                                                : in_item_i.vec_real;
  assign aim_d = in_item_i.vec_imag[VecWidth-1] ? (~in_item_i.vec_imag + 32'd1)
                                                : in_item_i.vec_imag;

  always_comb begin
    for (int k = 1; k <= RootSteps; k++) begin
      trial[k] = root_q[k-1] + (SqWidth'(1) << (2 * (RootSteps - k)));
      take[k]  = rem_q[k-1] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
      for (int k = 0; k <= RootSteps; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      abs_vld_q <= in_valid_i;
      sq_vld_q  <= abs_vld_q;
      vld_q[0]  <= sq_vld_q;
      for (int k = 1; k <= RootSteps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      are_q           <= are_d;
      aim_a_q         <= aim_d;
      side_a_q.zero   <= (in_item_i.vec_real == '0) && (in_item_i.vec_imag == '0);
      side_a_q.re_pos <= !in_item_i.vec_real[VecWidth-1] && (in_item_i.vec_real != '0);
      side_a_q.im_neg <= in_item_i.vec_imag[VecWidth-1];

      sq_re_q  <= are_q * are_q;
      sq_im_q  <= aim_a_q * aim_a_q;
      aim_b_q  <= aim_a_q;
      side_b_q <= side_a_q;

      rem_q[0]  <= sq_re_q + sq_im_q;
      root_q[0] <= '0;
      aim_q[0]  <= aim_b_q;
      side_q[0] <= side_b_q;

      for (int k = 1; k <= RootSteps; k++) begin
        rem_q[k]  <= take[k] ? (rem_q[k-1] - trial[k]) : rem_q[k-1];
        root_q[k] <= take[k] ? ((root_q[k-1] >> 1) + (SqWidth'(1) << (2 * (RootSteps - k))))
                             : (root_q[k-1] >> 1);
        aim_q[k]  <= aim_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign root_o.vld  = vld_q[RootSteps];
  assign root_o.side = side_q[RootSteps];
  assign root_o.mag  = MagWidth'(root_q[RootSteps]);
  assign root_o.aim  = aim_q[RootSteps];

endmodule

### hw/rtl/fqa_div.sv
// Sine pipeline: restoring division of |imag| by the magnitude, one quotient bit a stage.
module fqa_div import fqa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fqa_root_t         root_i,
  output logic              vld_o,
  output fqa_side_t         side_o,
  output logic [FracBits:0] par_o
);

  localparam int unsigned DivSteps = FracBits + 1;
  localparam int unsigned RemWidth = MagWidth + 2;

  logic                vld_q  [1:DivSteps];
  logic [RemWidth-1:0] r_q    [1:DivSteps];
  logic [DivSteps-1:0] q_q    [1:DivSteps];
  logic [MagWidth-1:0] mag_q  [1:DivSteps];
  fqa_side_t           side_q [1:DivSteps];

  logic                vld_c  [DivSteps+1];
  logic [RemWidth-1:0] r_c    [DivSteps+1];
  logic [DivSteps-1:0] q_c    [DivSteps+1];
  logic [MagWidth-1:0] mag_c  [DivSteps+1];
  fqa_side_t           side_c [DivSteps+1];
  logic                ge     [1:DivSteps];

  always_comb begin
    vld_c[0]  = root_i.vld;
    r_c[0]    = {2'b00, root_i.aim};
    q_c[0]    = '0;
    mag_c[0]  = root_i.mag;
    side_c[0] = root_i.side;
    for (int j = 1; j <= DivSteps; j++) begin
      vld_c[j]  = vld_q[j];
      r_c[j]    = r_q[j];
      q_c[j]    = q_q[j];
      mag_c[j]  = mag_q[j];
      side_c[j] = side_q[j];
      ge[j]     = r_c[j-1] >= {2'b00, mag_c[j-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j <= DivSteps; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      for (int j = 1; j <= DivSteps; j++) vld_q[j] <= vld_c[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 1; j <= DivSteps; j++) begin
        r_q[j]    <= (ge[j] ? (r_c[j-1] - {2'b00, mag_c[j-1]}) : r_c[j-1]) << 1;
        q_q[j]    <= {q_c[j-1][DivSteps-2:0], ge[j]};
        mag_q[j]  <= mag_c[j-1];
        side_q[j] <= side_c[j-1];
      end
    end
  end

  assign vld_o  = vld_c[DivSteps];
  assign side_o = side_c[DivSteps];
  assign par_o  = q_c[DivSteps];

endmodule

### hw/rtl/fqa_lookup.sv
// Arcsine ROM lookup, linear interpolation, quadrant mapping and result register.
module fqa_lookup import fqa_pkg::*; #(
  parameter int unsigned FracBits  = FracBitsDef,
  parameter int unsigned TableBits = TableBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  fqa_side_t         side_i,
  input  logic [FracBits:0] par_i,
  output logic              out_valid_o,
  output fqa_out_t          out_item_o
);

  localparam int unsigned IdxW     = TableBits + 1;
  localparam int unsigned RomDepth = (2 ** TableBits) + 1;
  localparam int unsigned Drop     = RomFrac - FracBits;
  localparam int unsigned ProdW    = RomWidth + FracBits;
  localparam int unsigned TW       = FracBits + 2;
  localparam logic [TW-1:0] One    = TW'(1) << FracBits;
  localparam logic [TW-1:0] Half   = One >> 1;

  typedef logic [RomWidth-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < RomDepth; i++) r[i] = arcsine_entry(i, TableBits);
    return r;
  endfunction

  localparam rom_t RomTable = build_rom();

  logic [IdxW-1:0]     idx;
  logic [IdxW-1:0]     addr_a_q;
  logic [IdxW-1:0]     addr_b_q;
  logic [FracBits-1:0] frac1_q;
  logic                full1_q;
  fqa_side_t           side1_q;

  logic [RomWidth-1:0] y1_q;
  logic [RomWidth-1:0] y2_q;
  logic [FracBits-1:0] frac2_q;
  logic                full2_q;
  fqa_side_t           side2_q;

  logic [RomWidth-1:0] dy;
  logic [ProdW-1:0]    prod_q;
  logic [TW-1:0]       base_q;
  fqa_side_t           side3_q;

  logic [TW-1:0]       t_sum;
  logic [TW-1:0]       t_clip;
  logic [TW-1:0]       angle;
  logic [TW-1:0]       angle_clip;

  logic                vld1_q;
  logic                vld2_q;
  logic                vld3_q;
  logic                out_valid_q;
  fqa_out_t            out_item_q;

  assign idx = IdxW'(par_i >> (FracBits - TableBits));
  assign dy  = (y2_q > y1_q) ? (y2_q - y1_q) : '0;

  always_comb begin
    t_sum  = base_q + TW'(prod_q >> RomFrac);
    t_clip = (t_sum > One) ? One : t_sum;
    if (!side3_q.im_neg) begin
      if (side3_q.re_pos) angle = t_clip;
      else                angle = (Half >= t_clip) ? (Half - t_clip) : '0;
    end else begin
      if (side3_q.re_pos) angle = One - t_clip;
      else                angle = Half + t_clip;
    end
    angle_clip = (angle > One) ? One : angle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      vld1_q      <= vld_i;
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      out_valid_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // a sine of exactly one reads the last entry on both ports
      addr_a_q <= idx;
      addr_b_q <= idx[TableBits] ? idx : (idx + IdxW'(1));
      frac1_q  <= FracBits'(par_i << TableBits);
      full1_q  <= idx[TableBits];
      side1_q  <= side_i;

      y1_q    <= RomTable[addr_a_q];
      y2_q    <= RomTable[addr_b_q];
      frac2_q <= frac1_q;
      full2_q <= full1_q;
      side2_q <= side1_q;

      prod_q  <= full2_q ? '0 : (ProdW'(dy) * ProdW'(frac2_q));
      base_q  <= TW'(y1_q >> Drop);
      side3_q <= side2_q;

      out_item_q.zero_vector <= side3_q.zero;
      out_item_q.angle_turns <= side3_q.zero ? '0 : AngleWidth'(angle_clip);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### test/tb.sv
// Self-checking testbench for the four-quadrant vector angle pipeline.
module tb import fqa_pkg::*; ();

  localparam int unsigned FracW    = 20;
  localparam int unsigned TabW     = 10;
  localparam int unsigned RomLen   = (1 << TabW) + 1;
  localparam int unsigned Latency  = FracW + 40;
  localparam longint unsigned One  = 64'd1 << FracW;
  localparam int unsigned NumRand  = 400;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  fqa_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  fqa_out_t out_item_o;

  four_quadrant_angle_from_vector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // One row of the directed table: the vector and, where obvious, its angle.
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    bit                 known;
    fqa_out_t           angle;
  } vec_row_t;

  logic [RomWidth-1:0] asin_turns [RomLen];
  fqa_out_t            angle_queue [$];
  int                  mismatches;
  bit                  sending_done;

  // Table entry i: asin(i/2^TabW)/(2*pi) in Q30 turns, built by integer CORDIC.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem, root, b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [RomWidth-1:0] asin_point(input int unsigned i);
    longint          x, y, z, dx, dy;
    longint unsigned s;
    if (i == 0) return '0;
    if (i >= (1 << TabW)) return RomWidth'(64'd1 << 28);
    s = longint'(i) << (30 - TabW);
    y = longint'(s);
    x = longint'(int_sqrt((64'd1 << 60) - s * s));
    z = 0;
    for (int k = 0; k < CordicSteps; k++) begin
      // Arithmetic shift floors, rounding negative values toward minus infinity.
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + CordicAngle[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - CordicAngle[k];
      end
    end
    if (z < 0) z = 0;
    z = (z + 2) >>> 2;
    if (z > (64'sd1 <<< 28)) z = 64'sd1 <<< 28;
    return RomWidth'(z);
  endfunction

  // Predict the angle of one vector in Q20 turns.
  function automatic fqa_out_t vector_angle(input fqa_in_t v);
    fqa_out_t        r;
    longint          re, im;
    longint unsigned are, aim, mag, sine, idx, frac, t, y1, y2, dy, ang;
    re = longint'(v.vec_real);
    im = longint'(v.vec_imag);
    r  = '0;
    if (re == 0 && im == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    are  = (re < 0) ? -re : re;
    aim  = (im < 0) ? -im : im;
    mag  = int_sqrt(are * are + aim * aim);
    if (mag == 0) mag = 1;
    sine = (aim << FracW) / mag;
    if (sine > One) sine = One;
    idx = sine >> (FracW - TabW);
    if (idx >= RomLen - 1) begin
      // A sine of exactly one takes the last entry without interpolation.
      t = longint'(asin_turns[RomLen-1]) >> (30 - FracW);
    end else begin
      y1   = asin_turns[idx];
      y2   = asin_turns[idx+1];
      dy   = (y2 > y1) ? y2 - y1 : 0;
      frac = (sine << TabW) & (One - 1);
      t    = (y1 >> (30 - FracW)) + ((dy * frac) >> 30);
    end
    if (t > One) t = One;
    // A zero real part belongs to the left half-plane.
    if (im >= 0) ang = (re > 0) ? t : (((One >> 1) >= t) ? (One >> 1) - t : 0);
    else         ang = (re > 0) ? One - t : (One >> 1) + t;
    if (ang > One) ang = One;
    r.angle_turns = ang[AngleWidth-1:0];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always #4 clk_i = ~clk_i;

  // Offer one vector and hold it until the block takes it.
  task automatic send_vector(input fqa_in_t v);
    in_valid_i <= 1'b1;
    in_item_i  <= v;
    angle_queue.push_back(vector_angle(v));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_input(input int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random vector: full-range bits, small magnitudes, axes and diagonals.
  function automatic fqa_in_t random_vector();
    fqa_in_t v;
    int unsigned kind;
    int unsigned sh;
    kind = $urandom_range(9);
    v.vec_real = $urandom();
    v.vec_imag = $urandom();
    case (kind)
      0: begin
        sh = $urandom_range(31);
        v.vec_real = $signed(v.vec_real) >>> sh;
        v.vec_imag = $signed(v.vec_imag) >>> $urandom_range(31);
      end
      1: v.vec_real = '0;
      2: v.vec_imag = '0;
      3: v.vec_imag = ($urandom_range(1)) ? v.vec_real : -v.vec_real;
      4: begin
        v.vec_real = $signed(v.vec_real) >>> 28;
        v.vec_imag = $signed(v.vec_imag) >>> 28;
      end
      default: ;
    endcase
    return v;
  endfunction

  // Stimulus: directed table first, then random vectors.
  initial begin
    vec_row_t rows [$];
    fqa_in_t  v;
    fqa_out_t a;
    int       n_rom;
    for (n_rom = 0; n_rom < RomLen; n_rom++) asin_turns[n_rom] = asin_point(n_rom);
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    sending_done = 1'b0;
    // Zero vector gives angle 0 and the flag; axes give the quarter points.
    rows.push_back('{0, 0, 1, '{21'd0, 1'b1}});
    rows.push_back('{1 << 20, 0, 1, '{21'd0, 1'b0}});
    rows.push_back('{0, 1 << 20, 1, '{21'd262144, 1'b0}});
    rows.push_back('{-(1 << 20), 0, 1, '{21'd524288, 1'b0}});
    rows.push_back('{0, -(1 << 20), 1, '{21'd786432, 1'b0}});
    rows.push_back('{32'sh7fffffff, 0, 1, '{21'd0, 1'b0}});
    rows.push_back('{32'sh80000000, 0, 1, '{21'd524288, 1'b0}});
    rows.push_back('{0, 32'sh7fffffff, 1, '{21'd262144, 1'b0}});
    rows.push_back('{0, 32'sh80000000, 1, '{21'd786432, 1'b0}});
    rows.push_back('{0, 1, 1, '{21'd262144, 1'b0}});
    rows.push_back('{-1, 0, 1, '{21'd524288, 1'b0}});
    rows.push_back('{1, 0, 1, '{21'd0, 1'b0}});
    // Remaining rows go through the predictor: diagonals, extremes, off-axis.
    rows.push_back('{32'sh80000000, 32'sh80000000, 0, '0});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 0, '0});
    rows.push_back('{32'sh7fffffff, 32'sh80000000, 0, '0});
    rows.push_back('{32'sh80000000, 32'sh7fffffff, 0, '0});
    rows.push_back('{1, 1, 0, '0});
    rows.push_back('{-1, -1, 0, '0});
    rows.push_back('{1, -1, 0, '0});
    rows.push_back('{-1, 1, 0, '0});
    rows.push_back('{1000000, 3, 0, '0});
    rows.push_back('{3, -1000000, 0, '0});
    rows.push_back('{-12345678, 23456789, 0, '0});
    rows.push_back('{32'sh55555555, 32'shaaaaaaaa, 0, '0});
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      v.vec_real = rows[i].re;
      v.vec_imag = rows[i].im;
      if (rows[i].known) begin
        a = vector_angle(v);
        // Hand-read angles must agree with the predictor too.
        if (a != rows[i].angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: predictor %h, hand value %h", i, a, rows[i].angle);
        end
      end
      send_vector(v);
      idle_input($urandom_range(1));
    end
    for (int i = 0; i < NumRand; i++) begin
      send_vector(random_vector());
      idle_input(gap_len());
    end
    in_valid_i   <= 1'b0;
    sending_done <= 1'b1;
  end

  // Receiver: one long hold-off early in the run, then random stalls.
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    // Hold the output long enough for the pipeline to fill and stall its input.
    out_stall_i <= 1'b1;
    repeat (3 * Latency) @(posedge clk_i);
    out_stall_i <= 1'b0;
    forever begin
      // Advance without stalls for a while, then stall for a random gap.
      repeat ($urandom_range(20, 1)) @(posedge clk_i);
      n = gap_len();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    fqa_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", out_item_o);
      end else begin
        want = angle_queue.pop_front();
        if (out_item_o.angle_turns !== want.angle_turns ||
            out_item_o.zero_vector !== want.zero_vector) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: expected %0d/%0b, got %0d/%0b",
                     want.angle_turns, want.zero_vector,
                     out_item_o.angle_turns, out_item_o.zero_vector);
        end
      end
    end
  end

  // Drain, settle, then report.
  initial begin
    wait (sending_done);
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Drop out if the run hangs.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hw/rtl/fqa_pkg.sv
hw/rtl/fqa_sqrt.sv
hw/rtl/fqa_div.sv
hw/rtl/fqa_lookup.sv
hw/rtl/four_quadrant_angle_from_vector_top.sv
test/tb.sv
